// ----- hdl/fsbm_pkg.sv -----
// Shared types and constants for the full-search block matcher.
// Used by full_search_block_match_top, fsbm_checker and the testbench; no dependencies.
package fsbm_pkg;

  // Store sizes
  localparam int MAX_BLOCK = 32;
  localparam int MAX_WIN   = 128;

  // Derived widths
  localparam int BLK_W   = $clog2(MAX_BLOCK);      // template row/col index
  localparam int WIN_W   = $clog2(MAX_WIN);        // window row/col index
  localparam int NB_W    = $clog2(MAX_BLOCK + 1);  // clamped block size
  localparam int NW_W    = $clog2(MAX_WIN + 1);    // clamped window size
  localparam int TADDR_W = 2 * BLK_W;
  localparam int WADDR_W = 2 * WIN_W;

  // Fixed field widths
  localparam int SCORE_W = 26;
  localparam int POS_W   = 13;
  localparam int SQ_W    = 16;

  // Input word kind (carried on s_tuser)
  typedef enum logic [1:0] {
    CMD_TEMPLATE = 2'd0,
    CMD_WINDOW   = 2'd1,
    CMD_SEARCH   = 2'd2
  } cmd_t;

  // Register index (paddr[4:2])
  typedef enum logic [2:0] {
    REG_BLOCK_SIZE  = 3'd0,
    REG_WINDOW_ROWS = 3'd1,
    REG_WINDOW_COLS = 3'd2,
    REG_ORIGIN_ROW  = 3'd3,
    REG_ORIGIN_COL  = 3'd4
  } reg_idx_t;

  // Search sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TSUM,
    ST_TWAIT,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_t;

endpackage

// ----- hdl/full_search_block_match_top.sv -----
// Full-search SSD block matcher: template and window stores, search sequencer,
// SSD pipeline and best-match tracking. Depends on fsbm_pkg.
//
//  channel   direction  signals                                  word
//  s_*       in         s_tvalid s_tready s_tdata s_tuser        load pixel / search command
//  m_*       out        m_tvalid m_tready m_tdata m_tuser        match result
//  apb       in/out     psel penable pwrite paddr pwdata prdata  config registers
//
// A pixel load or an unused command is taken in idle and leaves the sequencer
// there. A search first reads the n*n template (n = block size), then the n*n
// pixels of every placement: one template and one window memory read per cycle,
// with a single-port read each. Reset clears the control state and registers
// only; both stores hold undefined data until written. The result waits in the
// output register while m_tready is low, and the next word is taken meanwhile;
// a following search completes into that register only once it is free.
module full_search_block_match_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // row[6:0], col[13:7], pixel[21:14], zero[23:22]
  input  logic [1:0]  s_tuser,   // command[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // best_row[12:0], best_col[25:13], best_score[51:26], zero[55:52]
  output logic        m_tuser,   // found
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fsbm_pkg::*;

  // Configuration registers
  logic [5:0]  block_size;
  logic [7:0]  window_rows;
  logic [7:0]  window_cols;
  logic [11:0] origin_row;
  logic [11:0] origin_col;

  // Input fields
  logic [6:0]  in_row;
  logic [6:0]  in_col;
  logic [7:0]  in_pixel;
  logic [15:0] in_row_x;
  logic [15:0] in_col_x;
  cmd_t        cmd;
  logic        in_acc;

  // Stores
  logic [7:0] tmem [2**TADDR_W];
  logic [7:0] wmem [2**WADDR_W];

  // Sequencer
  state_t state;
  state_t state_next;
  logic   issue;
  logic   issue_tsum;
  logic   search_start;
  logic   out_load;

  // Clamped sizes and placement limits
  logic [NB_W-1:0]  n;
  logic [NW_W-1:0]  wr;
  logic [NW_W-1:0]  wc;
  logic [BLK_W-1:0] nm1;
  logic             fits;
  logic [WIN_W-1:0] rlim;
  logic [WIN_W-1:0] clim;

  // Scan counters
  logic [BLK_W-1:0] u;
  logic [BLK_W-1:0] v;
  logic [WIN_W-1:0] pi;
  logic [WIN_W-1:0] pj;
  logic             blk_end;
  logic             scan_end;
  logic [TADDR_W-1:0] taddr;
  logic [WADDR_W-1:0] waddr;

  // Pipeline
  logic             s1_v;
  logic             s1_tsum;
  logic             s1_first;
  logic             s1_last;
  logic [WIN_W-1:0] s1_pi;
  logic [WIN_W-1:0] s1_pj;
  logic [7:0]       t_q;
  logic [7:0]       w_q;
  logic signed [8:0]  diff;
  logic signed [17:0] prod;
  logic             s2_v;
  logic             s2_first;
  logic             s2_last;
  logic [WIN_W-1:0] s2_pi;
  logic [WIN_W-1:0] s2_pj;
  logic [SQ_W-1:0]  sq;
  logic [SCORE_W-1:0] acc;
  logic [SCORE_W-1:0] acc_next;
  logic             sc_v;
  logic [SCORE_W-1:0] sc;
  logic [WIN_W-1:0] sc_pi;
  logic [WIN_W-1:0] sc_pj;

  // Best match
  logic               nz;
  logic               have;
  logic [SCORE_W-1:0] best;
  logic [WIN_W-1:0]   br;
  logic [WIN_W-1:0]   bc;

  // Field unpacking
  assign in_row   = s_tdata[6:0];
  assign in_col   = s_tdata[13:7];
  assign in_pixel = s_tdata[21:14];
  assign in_row_x = {9'b0, in_row};
  assign in_col_x = {9'b0, in_col};
  assign cmd      = cmd_t'(s_tuser);
  assign in_acc   = s_tvalid & s_tready;

  // APB registers; pready tied high
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size  <= 6'd8;
      window_rows <= 8'd64;
      window_cols <= 8'd64;
      origin_row  <= 12'd0;
      origin_col  <= 12'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_BLOCK_SIZE:  block_size  <= pwdata[5:0];
        REG_WINDOW_ROWS: window_rows <= pwdata[7:0];
        REG_WINDOW_COLS: window_cols <= pwdata[7:0];
        REG_ORIGIN_ROW:  origin_row  <= pwdata[11:0];
        REG_ORIGIN_COL:  origin_col  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_BLOCK_SIZE:  prdata = {26'b0, block_size};
      REG_WINDOW_ROWS: prdata = {24'b0, window_rows};
      REG_WINDOW_COLS: prdata = {24'b0, window_cols};
      REG_ORIGIN_ROW:  prdata = {20'b0, origin_row};
      REG_ORIGIN_COL:  prdata = {20'b0, origin_col};
      default:         prdata = 32'b0;
    endcase
  end

  // Clamp sizes to the store limits; the user must keep config stable during a search, the block does not enforce it
  assign n    = (32'(block_size) > MAX_BLOCK) ? NB_W'(MAX_BLOCK) : NB_W'(block_size);
  assign wr   = (32'(window_rows) > MAX_WIN) ? NW_W'(MAX_WIN) : NW_W'(window_rows);
  assign wc   = (32'(window_cols) > MAX_WIN) ? NW_W'(MAX_WIN) : NW_W'(window_cols);
  assign nm1  = BLK_W'(32'(n) - 32'd1);
  assign fits = (32'(n) <= 32'(wr)) && (32'(n) <= 32'(wc));
  assign rlim = WIN_W'(32'(wr) - 32'(n));
  assign clim = WIN_W'(32'(wc) - 32'(n));

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && cmd == CMD_SEARCH) begin
          state_next = (n == '0) ? ST_DONE : ST_TSUM;
        end
      end
      ST_TSUM: begin
        if (blk_end) begin
          state_next = ST_TWAIT;
        end
      end
      ST_TWAIT: begin
        if (!s1_v) begin
          state_next = (nz && fits) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!s1_v && !s2_v && !sc_v) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready     = 1'b0;
    issue        = 1'b0;
    issue_tsum   = 1'b0;
    search_start = 1'b0;
    out_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready     = 1'b1;
        search_start = in_acc && cmd == CMD_SEARCH;
      end
      ST_TSUM: begin
        issue      = 1'b1;
        issue_tsum = 1'b1;
      end
      ST_SCAN:  issue = 1'b1;
      ST_DONE:  out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan counters: pixel (u,v) inside placement (pi,pj)
  assign blk_end  = (u == nm1) && (v == nm1);
  assign scan_end = blk_end && (pi == rlim) && (pj == clim);

  always_ff @(posedge clk) begin
    if (search_start) begin
      u  <= '0;
      v  <= '0;
      pi <= '0;
      pj <= '0;
    end else if (issue) begin
      if (v == nm1) begin
        v <= '0;
        u <= (u == nm1) ? '0 : u + 1'b1;
      end else begin
        v <= v + 1'b1;
      end
      if (!issue_tsum && blk_end) begin
        if (pj == clim) begin
          pj <= '0;
          pi <= pi + 1'b1;
        end else begin
          pj <= pj + 1'b1;
        end
      end
    end
  end

  assign taddr = {u, v};
  assign waddr = {WIN_W'(32'(pi) + 32'(u)), WIN_W'(32'(pj) + 32'(v))};

  // Stores: writes only in idle, reads only during a search, so no overlap
  always_ff @(posedge clk) begin
    if (in_acc && cmd == CMD_TEMPLATE && in_row < 7'(MAX_BLOCK) && in_col < 7'(MAX_BLOCK)) begin
      tmem[{in_row_x[BLK_W-1:0], in_col_x[BLK_W-1:0]}] <= in_pixel;
    end
    if (issue) begin
      t_q <= tmem[taddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && cmd == CMD_WINDOW && 32'(in_row) < MAX_WIN && 32'(in_col) < MAX_WIN) begin
      wmem[{in_row_x[WIN_W-1:0], in_col_x[WIN_W-1:0]}] <= in_pixel;
    end
    if (issue) begin
      w_q <= wmem[waddr];
    end
  end

  // Stage 1 tags travel with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= issue;
    end
    s1_tsum  <= issue_tsum;
    s1_first <= (u == '0) && (v == '0);
    s1_last  <= blk_end;
    s1_pi    <= pi;
    s1_pj    <= pj;
  end

  // Template-in-use nonzero check
  always_ff @(posedge clk) begin
    if (search_start) begin
      nz <= 1'b0;
    end else if (s1_v && s1_tsum && t_q != 8'd0) begin
      nz <= 1'b1;
    end
  end

  // Stage 2: squared difference
  assign diff = $signed({1'b0, t_q}) - $signed({1'b0, w_q});
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v && !s1_tsum;
    end
    sq       <= prod[SQ_W-1:0];
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_pi    <= s1_pi;
    s2_pj    <= s1_pj;
  end

  // Stage 3: accumulate over the placement
  assign acc_next = (s2_first ? '0 : acc) + SCORE_W'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_v <= 1'b0;
    end else begin
      sc_v <= s2_v && s2_last;
    end
    if (s2_v) begin
      acc <= acc_next;
    end
    sc    <= acc_next;
    sc_pi <= s2_pi;
    sc_pj <= s2_pj;
  end

  // Stage 4: keep the earliest lowest score
  always_ff @(posedge clk) begin
    if (search_start) begin
      have <= 1'b0;
    end else if (sc_v && (!have || sc < best)) begin
      have <= 1'b1;
      best <= sc;
      br   <= sc_pi;
      bc   <= sc_pj;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_tuser <= have;
      if (have) begin
        m_tdata <= {4'b0, best,
                    POS_W'(origin_col) + POS_W'(bc),
                    POS_W'(origin_row) + POS_W'(br)};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

// ----- hdl/fsbm_checker.sv -----
// Port-level checks for full_search_block_match_top, bound to the top level.
// Depends on fsbm_pkg for the command codes.
module fsbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  import fsbm_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // No match reports all-zero position and score
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 56'd0)
    else $error("no-match result carries nonzero data");

  // Padding bits above the score stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[55:52] == 4'd0)
    else $error("result padding nonzero");

  // A word that is not a search never raises a result
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != CMD_SEARCH && !m_tvalid |=> !m_tvalid)
    else $error("result produced by a non-search word");

endmodule

bind full_search_block_match_top fsbm_checker u_fsbm_checker (.*);

// ----- test/tb_full_search_block_match_top.sv -----
// Self-checking testbench for full_search_block_match_top: pixel loads and SSD
// searches on the input stream, results checked against an in-bench predictor.
// Depends on fsbm_pkg and the block's RTL; reads no files.
module tb_full_search_block_match_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fsbm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int SETTLE       = 16;
  localparam int RANDOM_WORDS = 380;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [SCORE_W-1:0] score;
  } match_t;

  localparam match_t NO_MATCH = '0;

  typedef enum logic { ROW_REG, ROW_WORD } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] value;
    logic [1:0]  cmd;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [7:0]  pix;
    bit          typed;
    match_t      want;
  } stim_row_t;

  // DUT signals
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // row[6:0], col[13:7], pixel[21:14], zero[23:22]
  logic [1:0]  s_tuser = '0;   // command[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // best_row[12:0], best_col[25:13], best_score[51:26]
  logic        m_tuser;        // found
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: pixel stores and register shadows
  logic [7:0]  template_px [MAX_BLOCK*MAX_BLOCK] = '{default: '0};
  logic [7:0]  window_px   [MAX_WIN*MAX_WIN]     = '{default: '0};
  logic [5:0]  blk_reg  = 6'd8;
  logic [7:0]  rows_reg = 8'd64;
  logic [7:0]  cols_reg = 8'd64;
  logic [11:0] orow_reg = '0;
  logic [11:0] ocol_reg = '0;

  match_t      pending_matches [$];
  stim_row_t   plan [$];

  int  mismatches = 0;
  int  loads_done = 0;
  int  searches_done = 0;
  int  empty_results = 0;
  int  reg_writes = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  int  sink_hold = 0;
  int  sink_quiet = 0;
  int  sink_roll;

  full_search_block_match_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Full search over the shadow stores: lowest SSD, first placement on a tie
  function automatic match_t predict_match();
    int unsigned n, wr, wc, tsum, acc, best;
    int          d, i, j, pr, pc, br, bc;
    bit          have;
    match_t      m;
    n  = (blk_reg > MAX_BLOCK) ? MAX_BLOCK : blk_reg;
    wr = (rows_reg > MAX_WIN) ? MAX_WIN : rows_reg;
    wc = (cols_reg > MAX_WIN) ? MAX_WIN : cols_reg;
    tsum = 0;
    have = 1'b0;
    best = 0;
    br = 0;
    bc = 0;
    for (i = 0; i < n; i++)
      for (j = 0; j < n; j++)
        tsum += template_px[i*MAX_BLOCK + j];
    if (tsum != 0 && n <= wr && n <= wc) begin
      for (pr = 0; pr + n <= wr; pr++) begin
        for (pc = 0; pc + n <= wc; pc++) begin
          acc = 0;
          for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
              d = int'(template_px[i*MAX_BLOCK + j]) -
                  int'(window_px[(pr + i)*MAX_WIN + pc + j]);
              acc += d * d;
            end
          end
          if (!have || acc < best) begin
            have = 1'b1;
            best = acc;
            br = pr;
            bc = pc;
          end
        end
      end
    end
    if (!have) return NO_MATCH;
    m.found = 1'b1;
    m.row   = POS_W'(orow_reg + br);
    m.col   = POS_W'(ocol_reg + bc);
    m.score = SCORE_W'(best);
    return m;
  endfunction

  // Source gap: mostly back to back, some short, a few long
  function automatic int idle_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mode 0: full range, 1: narrow range (ties), 2: only 0 and 255
  function automatic logic [7:0] gen_pixel(int mode);
    if (mode == 1) return 8'($urandom_range(0, 3));
    if (mode == 2) return {8{1'($urandom_range(0, 1))}};
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [11:0] pick_origin();
    case ($urandom_range(0, 3))
      0: return 12'd0;
      1: return 12'd4095;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic void add_reg(reg_idx_t idx, logic [31:0] value);
    stim_row_t s;
    s = '{kind: ROW_REG, idx: idx, value: value, cmd: '0, row: '0, col: '0, pix: '0,
          typed: 1'b0, want: NO_MATCH};
    plan.push_back(s);
  endfunction

  function automatic void add_word(logic [1:0] cmd, logic [6:0] r, logic [6:0] c,
                                   logic [7:0] px, bit typed = 1'b0,
                                   match_t want = NO_MATCH);
    stim_row_t s;
    s = '{kind: ROW_WORD, idx: REG_BLOCK_SIZE, value: '0, cmd: cmd, row: r, col: c,
          pix: px, typed: typed, want: want};
    plan.push_back(s);
  endfunction

  // Send one input word and update the predictor when it is taken
  task automatic push_word(input logic [1:0] cmd, input logic [6:0] r, input logic [6:0] c,
                           input logic [7:0] px, input bit typed = 1'b0,
                           input match_t want = NO_MATCH);
    int     gap;
    match_t m;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, px, c, r};
    do @(posedge clk); while (!s_tready);
    case (cmd)
      CMD_TEMPLATE: begin
        if (r < MAX_BLOCK && c < MAX_BLOCK) template_px[r*MAX_BLOCK + c] = px;
        loads_done++;
      end
      CMD_WINDOW: begin
        window_px[r*MAX_WIN + c] = px;
        loads_done++;
      end
      CMD_SEARCH: begin
        m = typed ? want : predict_match();
        pending_matches.push_back(m);
        searches_done++;
        if (!m.found) empty_results++;
      end
      default: ;
    endcase
  endtask

  // Drop valid, drain all results, then let trailing loads retire
  task automatic quiesce();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BLOCK_SIZE:  blk_reg  = value[5:0];
      REG_WINDOW_ROWS: rows_reg = value[7:0];
      REG_WINDOW_COLS: cols_reg = value[7:0];
      REG_ORIGIN_ROW:  orow_reg = value[11:0];
      REG_ORIGIN_COL:  ocol_reg = value[11:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic take_result(input match_t got);
    match_t want;
    if (pending_matches.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result at %0t: found=%0b row=%0d col=%0d score=%0d",
                 $time, got.found, got.row, got.col, got.score);
      return;
    end
    want = pending_matches.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch at %0t: expected found=%0b row=%0d col=%0d score=%0d, ",
                  "got found=%0b row=%0d col=%0d score=%0d"},
                 $time, want.found, want.row, want.col, want.score,
                 got.found, got.row, got.col, got.score);
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      take_result({m_tuser, m_tdata[12:0], m_tdata[25:13], m_tdata[51:26]});
  end

  // Sink stalls, with occasional stretches of steady ready
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else if (sink_quiet > 0) begin
      sink_quiet--;
      m_tready <= 1'b1;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 4) sink_quiet = $urandom_range(50, 400);
      else if (sink_roll < 35) sink_hold = stall_len();
      m_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_matches.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : main
    int          i, j, k, n, wr, wc, top, len, roll, pix_mode, rand_words;
    bit          zero_tmpl;
    logic [1:0]  cmd;
    logic [6:0]  r, c;

    rand_words = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill every pixel any search may read: the top left 8x8 template corner,
    // the top left 16x16 window corner, plus window row 0 and column 0 out to the edge
    for (i = 0; i < 8; i++)
      for (j = 0; j < 8; j++)
        push_word(CMD_TEMPLATE, 7'(i), 7'(j), gen_pixel(0));
    for (i = 0; i < 16; i++)
      for (j = 0; j < 16; j++)
        push_word(CMD_WINDOW, 7'(i), 7'(j), gen_pixel(0));
    for (i = 16; i < MAX_WIN; i++) begin
      push_word(CMD_WINDOW, 7'd0, 7'(i), gen_pixel(0));
      push_word(CMD_WINDOW, 7'(i), 7'd0, gen_pixel(0));
    end

    // Directed cases
    add_reg(REG_WINDOW_ROWS, 16);
    add_reg(REG_WINDOW_COLS, 16);
    add_reg(REG_BLOCK_SIZE, 0);                          // empty block: no match
    add_word(CMD_SEARCH, 7'd0, 7'd0, 8'd0, 1'b1, NO_MATCH);
    add_reg(REG_BLOCK_SIZE, 1);
    add_word(CMD_TEMPLATE, 7'd0, 7'd0, 8'd0);            // all-zero template
    add_word(CMD_SEARCH, 7'd127, 7'd127, 8'd255, 1'b1, NO_MATCH);
    add_word(CMD_TEMPLATE, 7'd0, 7'd0, 8'd255);
    add_word(CMD_WINDOW, 7'd15, 7'd15, 8'd0);
    add_word(CMD_SEARCH, 7'd0, 7'd0, 8'd0);
    add_reg(REG_BLOCK_SIZE, 8);
    add_reg(REG_WINDOW_ROWS, 8);                         // block fills window: one placement
    add_reg(REG_WINDOW_COLS, 8);
    add_word(CMD_SEARCH, 7'd0, 7'd0, 8'd0);
    add_reg(REG_WINDOW_ROWS, 7);                         // block taller than window
    add_word(CMD_SEARCH, 7'd0, 7'd0, 8'd0, 1'b1, NO_MATCH);
    add_reg(REG_WINDOW_ROWS, 0);
    add_word(CMD_SEARCH, 7'd0, 7'd0, 8'd0, 1'b1, NO_MATCH);
    add_reg(REG_BLOCK_SIZE, 1);
    add_reg(REG_WINDOW_ROWS, 255);                       // clamps to 128 rows
    add_reg(REG_WINDOW_COLS, 1);
    add_reg(REG_ORIGIN_ROW, 4095);
    add_reg(REG_ORIGIN_COL, 4095);
    add_word(CMD_SEARCH, 7'd0, 7'd0, 8'd0);
    add_reg(REG_WINDOW_ROWS, 1);
    add_reg(REG_WINDOW_COLS, 128);
    add_reg(REG_ORIGIN_ROW, 0);
    add_reg(REG_ORIGIN_COL, 0);
    add_word(CMD_SEARCH, 7'd0, 7'd0, 8'd0);
    add_word(CMD_UNUSED, 7'd127, 7'd127, 8'd255);        // unused command
    add_word(CMD_TEMPLATE, 7'd127, 7'd127, 8'd7);        // out of template range
    add_word(CMD_TEMPLATE, 7'd5, 7'd40, 8'd9);
    add_word(CMD_WINDOW, 7'd127, 7'd127, 8'd255);
    add_reg(REG_WINDOW_COLS, 2);                         // tie: first placement wins
    add_word(CMD_TEMPLATE, 7'd0, 7'd0, 8'd10);
    add_word(CMD_WINDOW, 7'd0, 7'd0, 8'd10);
    add_word(CMD_WINDOW, 7'd0, 7'd1, 8'd10);
    add_word(CMD_SEARCH, 7'd0, 7'd0, 8'd0, 1'b1,
             match_t'{1'b1, 13'd0, 13'd0, 26'd0});

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_REG) begin
        quiesce();
        write_reg(plan[k].idx, plan[k].value);
      end else begin
        push_word(plan[k].cmd, plan[k].row, plan[k].col, plan[k].pix,
                  plan[k].typed, plan[k].want);
      end
    end

    // Random phases: new settings, then loads with random content and searches
    while (rand_words < RANDOM_WORDS) begin
      quiesce();
      calm = ($urandom_range(0, 4) == 0);
      n   = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 5) : $urandom_range(6, 8);
      top = (n > 5) ? n + 3 : 16;
      wr  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : $urandom_range(n, top);
      wc  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : $urandom_range(n, top);
      write_reg(REG_BLOCK_SIZE, n);
      write_reg(REG_WINDOW_ROWS, wr);
      write_reg(REG_WINDOW_COLS, wc);
      write_reg(REG_ORIGIN_ROW, pick_origin());
      write_reg(REG_ORIGIN_COL, pick_origin());

      roll = $urandom_range(0, 99);
      pix_mode = (roll < 30) ? 1 : (roll < 40) ? 2 : 0;
      zero_tmpl = (n <= 4) && ($urandom_range(0, 9) == 0);
      if (zero_tmpl) begin
        for (i = 0; i < n; i++)
          for (j = 0; j < n; j++)
            push_word(CMD_TEMPLATE, 7'(i), 7'(j), 8'd0);
        rand_words += n * n;
      end

      len = $urandom_range(6, 20);
      for (k = 0; k <= len; k++) begin
        roll = (k == len) ? 99 : $urandom_range(0, 99);
        if (roll < 45 || (roll < 65 && zero_tmpl)) begin
          push_word(CMD_WINDOW, 7'($urandom_range(0, ((wr == 0) ? 1 : wr) - 1)),
                    7'($urandom_range(0, ((wc == 0) ? 1 : wc) - 1)), gen_pixel(pix_mode));
          rand_words++;
        end else if (roll < 65) begin
          push_word(CMD_TEMPLATE, 7'($urandom_range(0, n - 1)),
                    7'($urandom_range(0, n - 1)), gen_pixel(pix_mode));
          rand_words++;
        end else if (roll < 75) begin
          // noise: unused command or a load anywhere in the address range
          r = 7'($urandom_range(0, 127));
          c = 7'($urandom_range(0, 127));
          if ($urandom_range(0, 1)) begin
            push_word(CMD_UNUSED, r, c, gen_pixel(0));
          end else begin
            cmd = $urandom_range(0, 1) ? CMD_WINDOW : CMD_TEMPLATE;
            push_word(cmd, r, c, gen_pixel(0));
            if (cmd == CMD_WINDOW || (r < MAX_BLOCK && c < MAX_BLOCK)) rand_words++;
          end
        end else begin
          push_word(CMD_SEARCH, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                    gen_pixel(0));
          rand_words++;
        end
      end
    end

    // Drain and let the block settle
    quiesce();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d pixel loads and %0d searches, %0d of them without a match,",
             loads_done, searches_done, empty_results);
    $display("over %0d register writes with blocks up to 8 and windows up to 128 wide",
             reg_writes);
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               pending_matches.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/fsbm_pkg.sv
hdl/full_search_block_match_top.sv
hdl/fsbm_checker.sv
test/tb_full_search_block_match_top.sv
